/* design/tpn_pkg.sv */
`default_nettype none

package tpn_pkg;

   // character codes
   localparam logic [7:0] CH_NUL    = 8'd0;
   localparam logic [7:0] CH_SPACE  = 8'd32;
   localparam logic [7:0] CH_PERIOD = 8'd46;
   localparam logic [7:0] CH_COMMA  = 8'd44;
   localparam logic [7:0] CH_UPPER_A = 8'd65;
   localparam logic [7:0] CH_UPPER_Z = 8'd90;
   localparam logic [7:0] CH_LOWER_A = 8'd97;
   localparam logic [7:0] CH_LOWER_Z = 8'd122;
   localparam logic [7:0] CASE_GAP  = 8'd32;

   // held punctuation mark codes
   localparam logic [1:0] MARK_NONE   = 2'd0;
   localparam logic [1:0] MARK_PERIOD = 2'd1;
   localparam logic [1:0] MARK_COMMA  = 2'd2;

   // depth of the result buffer, most results one input beat can cause
   localparam int unsigned RES_DEPTH = 3;

   typedef struct packed {
      logic [7:0] out_char;
      logic       char_valid;
      logic       end_of_text;
   } res_entry_type;

endpackage

`default_nettype wire

/* design/text_punctuation_normalizer_top.sv */
`default_nettype none

// channel  | direction | ports                                      | accepted when
// ---------+-----------+--------------------------------------------+-----------------------
// req      | in        | req_in_char, req_last_char                 | req_valid & req_ready
// rsp      | out       | rsp_out_char, rsp_char_valid, rsp_end_of_text | rsp_valid & rsp_ready
//
// one input beat is handled in the cycle it is accepted; its results (0 to 3) land in
// a 3-entry result buffer and leave one per cycle while rsp_ready is high, the first offered in the next cycle
// a beat that yields at most one result sustains one beat per cycle while rsp_ready is high; a beat
// with k results holds the single result port until its last result is leaving before the next beat is taken
// req_ready is high while the buffer is empty or its last entry is leaving
// synchronous active-high reset clears the text flags and empties the buffer

module text_punctuation_normalizer_top (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_in_char,
   input  wire logic       req_last_char,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_char,
   output logic            rsp_char_valid,
   output logic            rsp_end_of_text
);

   import tpn_pkg::*;

   // text state
   logic [1:0] held_mark_ff, held_mark_in;
   logic       held_space_ff, held_space_in;
   logic       text_started_ff, text_started_in;
   logic       first_emitted_ff, first_emitted_in;

   // result buffer, entry 0 is the head
   res_entry_type res_ff [RES_DEPTH];
   res_entry_type res_in [RES_DEPTH];
   logic [1:0]    count_ff, count_in;

   logic req_take;
   logic rsp_take;

   // decode of the incoming byte
   logic       is_space;
   logic       is_mark;
   logic       is_other;
   logic [1:0] mark_after;    // held mark once the byte is folded in
   logic       space_after;   // held space once the byte is folded in
   logic [1:0] mark_out;      // mark emitted in this beat
   logic       space_out;     // space emitted in this beat
   logic       fe_char;       // first_emitted as seen by the current character
   logic [7:0] char_conv;

   // new results, compacted to the front
   res_entry_type new_res [RES_DEPTH];
   logic [1:0]    new_cnt;

   assign rsp_take  = rsp_valid & rsp_ready;
   assign req_ready = (count_ff == 2'd0) | ((count_ff == 2'd1) & rsp_ready);
   assign req_take  = req_valid & req_ready;

   assign rsp_valid       = (count_ff != 2'd0);
   assign rsp_out_char    = res_ff[0].out_char;
   assign rsp_char_valid  = res_ff[0].char_valid;
   assign rsp_end_of_text = res_ff[0].end_of_text;

   always_comb begin
      is_space = (req_in_char == CH_SPACE);
      is_mark  = (req_in_char == CH_PERIOD) | (req_in_char == CH_COMMA);
      is_other = ~is_space & ~is_mark;

      // fold the byte into the held mark and space
      if (is_space) begin
         mark_after  = held_mark_ff;
         space_after = held_space_ff | text_started_ff;
      end else if (is_mark) begin
         space_after = 1'b0;
         if (req_in_char == CH_COMMA) begin
            mark_after = MARK_COMMA;
         end else if (held_mark_ff == MARK_NONE) begin
            mark_after = MARK_PERIOD;
         end else begin
            mark_after = held_mark_ff;
         end
      end else begin
         // an ordinary character flushes what was held
         mark_after  = MARK_NONE;
         space_after = 1'b0;
      end

      // what gets flushed ahead of the character or at the end of text
      if (is_other) begin
         mark_out  = held_mark_ff;
         space_out = held_space_ff;
      end else if (req_last_char) begin
         mark_out  = mark_after;
         space_out = space_after;
      end else begin
         mark_out  = MARK_NONE;
         space_out = 1'b0;
      end

      // case folding, first emitted a-z goes upper, later A-Z go lower
      fe_char   = first_emitted_ff | (mark_out != MARK_NONE) | space_out;
      char_conv = req_in_char;
      if (req_in_char inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
         if (fe_char) begin
            char_conv = req_in_char + CASE_GAP;
         end
      end else if (!fe_char && (req_in_char inside {[CH_LOWER_A:CH_LOWER_Z]})) begin
         char_conv = req_in_char - CASE_GAP;
      end

      // pack results in order: mark, space, character
      for (int i = 0; i < RES_DEPTH; i++) begin
         new_res[i] = '0;
      end
      new_cnt = 2'd0;
      if (mark_out != MARK_NONE) begin
         new_res[new_cnt].out_char   = (mark_out == MARK_PERIOD) ? CH_PERIOD : CH_COMMA;
         new_res[new_cnt].char_valid = 1'b1;
         new_cnt = new_cnt + 2'd1;
      end
      if (space_out) begin
         new_res[new_cnt].out_char   = CH_SPACE;
         new_res[new_cnt].char_valid = 1'b1;
         new_cnt = new_cnt + 2'd1;
      end
      if (is_other) begin
         new_res[new_cnt].out_char   = char_conv;
         new_res[new_cnt].char_valid = 1'b1;
         new_cnt = new_cnt + 2'd1;
      end
      if (req_last_char) begin
         // nothing to show: a bare end marker
         if (new_cnt == 2'd0) begin
            new_res[0].out_char   = CH_NUL;
            new_res[0].char_valid = 1'b0;
            new_cnt = 2'd1;
         end
         new_res[new_cnt - 2'd1].end_of_text = 1'b1;
      end
   end

   // next text state
   always_comb begin
      held_mark_in     = held_mark_ff;
      held_space_in    = held_space_ff;
      text_started_in  = text_started_ff;
      first_emitted_in = first_emitted_ff;
      if (req_take) begin
         if (req_last_char) begin
            held_mark_in     = MARK_NONE;
            held_space_in    = 1'b0;
            text_started_in  = 1'b0;
            first_emitted_in = 1'b0;
         end else begin
            held_mark_in     = mark_after;
            held_space_in    = space_after;
            text_started_in  = text_started_ff | ~is_space;
            first_emitted_in = first_emitted_ff | (new_cnt != 2'd0);
         end
      end
   end

   // result buffer: load on accept (buffer is empty or its last entry is leaving then), else shift on pop
   always_comb begin
      res_in   = res_ff;
      count_in = count_ff;
      if (req_take) begin
         res_in   = new_res;
         count_in = new_cnt;
      end else if (rsp_take) begin
         for (int i = 0; i < RES_DEPTH - 1; i++) begin
            res_in[i] = res_ff[i + 1];
         end
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_mark_ff     <= MARK_NONE;
         held_space_ff    <= 1'b0;
         text_started_ff  <= 1'b0;
         first_emitted_ff <= 1'b0;
         count_ff         <= 2'd0;
      end else begin
         held_mark_ff     <= held_mark_in;
         held_space_ff    <= held_space_in;
         text_started_ff  <= text_started_in;
         first_emitted_ff <= first_emitted_in;
         count_ff         <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   // held mark only ever takes the none, period or comma codes
   a_mark_code: assert property (@(posedge clock) disable iff (reset)
      (held_mark_ff == MARK_NONE) || (held_mark_ff == MARK_PERIOD)
      || (held_mark_ff == MARK_COMMA))
      else $error("held mark has an unused code");

   // a space is only held once the text has started
   a_space_started: assert property (@(posedge clock) disable iff (reset)
      held_space_ff |-> text_started_ff)
      else $error("space held before text start");

   // the last beat of a text leaves every text flag cleared
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_last_char) |=>
      (held_mark_ff == MARK_NONE) && !held_space_ff && !text_started_ff && !first_emitted_ff)
      else $error("text state not cleared after last beat");

   // a result without a byte is only the bare end marker
   a_bare_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_char_valid) |-> (rsp_end_of_text && (rsp_out_char == CH_NUL)))
      else $error("empty result that is not an end marker");

endmodule

`default_nettype wire

/* bench/text_punctuation_normalizer_top_tb.sv */
`default_nettype none

module text_punctuation_normalizer_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tpn_pkg::*;

   // one input beat as the sender sees it
   typedef struct {
      logic [7:0] ch;
      logic       last;
   } char_beat_type;

   // dut ports, the driven inputs known from time zero
   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_char = 8'd0;
   logic       req_last_char = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_char;
   logic       rsp_char_valid;
   logic       rsp_end_of_text;

   // beats waiting for the driver, expected cleaned bytes waiting for the monitor
   char_beat_type text_q[$];
   res_entry_type clean_q[$];
   res_entry_type burst_q[$];
   char_beat_type next_beat;
   res_entry_type got_beat;
   res_entry_type want_beat;

   // predictor copy of the normalizer state
   logic [1:0] pend_mark = MARK_NONE;
   logic       pend_space = 1'b0;
   logic       seen_text = 1'b0;
   logic       cap_done = 1'b0;

   // idle odds in percent, changed per phase
   int unsigned send_idle_pct = 38;
   int unsigned recv_idle_pct = 71;

   int unsigned beats_pushed = 0;
   int unsigned beats_taken = 0;
   int unsigned bytes_seen = 0;
   int unsigned texts_done = 0;
   int unsigned errors = 0;

   text_punctuation_normalizer_top u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_in_char     (req_in_char),
      .req_last_char   (req_last_char),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_char    (rsp_out_char),
      .rsp_char_valid  (rsp_char_valid),
      .rsp_end_of_text (rsp_end_of_text)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   // one cleaned byte (or bare end marker) for the current step
   task automatic emit_byte(input logic [7:0] ch, input logic vld);
      res_entry_type r;
      r.out_char    = ch;
      r.char_valid  = vld;
      r.end_of_text = 1'b0;
      burst_q.push_back(r);
      if (vld) begin
         cap_done = 1'b1;
      end
   endtask

   // held mark goes out first, then the held space
   task automatic flush_held();
      if (pend_mark != MARK_NONE) begin
         emit_byte((pend_mark == MARK_PERIOD) ? CH_PERIOD : CH_COMMA, 1'b1);
      end
      if (pend_space) begin
         emit_byte(CH_SPACE, 1'b1);
      end
      pend_mark  = MARK_NONE;
      pend_space = 1'b0;
   endtask

   // work out the cleaned bytes one accepted beat causes and queue them
   task automatic normalize_beat(input logic [7:0] c, input logic last);
      logic [7:0] ch;
      burst_q.delete();
      if (c == CH_SPACE) begin
         // leading spaces vanish, later ones collapse into one held space
         if (seen_text) begin
            pend_space = 1'b1;
         end
      end else if (c == CH_PERIOD || c == CH_COMMA) begin
         // a space before a mark is dropped, marks in a run merge, comma wins
         seen_text  = 1'b1;
         pend_space = 1'b0;
         if (c == CH_COMMA) begin
            pend_mark = MARK_COMMA;
         end else if (pend_mark == MARK_NONE) begin
            pend_mark = MARK_PERIOD;
         end
      end else begin
         seen_text = 1'b1;
         flush_held();
         ch = c;
         if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
            // capitals fold to lower case except as the first byte out
            if (cap_done) begin
               ch = ch + CASE_GAP;
            end
         end else if (!cap_done && ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
            ch = ch - CASE_GAP;
         end
         emit_byte(ch, 1'b1);
      end
      if (last) begin
         flush_held();
         // nothing left to send: a bare end marker closes the text
         if (burst_q.size() == 0) begin
            emit_byte(CH_NUL, 1'b0);
         end
         burst_q[burst_q.size() - 1].end_of_text = 1'b1;
         pend_mark  = MARK_NONE;
         pend_space = 1'b0;
         seen_text  = 1'b0;
         cap_done   = 1'b0;
      end
      foreach (burst_q[i]) begin
         clean_q.push_back(burst_q[i]);
      end
   endtask

   // ---------------------------------------------------------------- driver

   // a held beat stays put until taken; a new one may follow in the next cycle
   always @(posedge clock) begin
      if (reset) begin
         req_valid     <= 1'b0;
         req_in_char   <= 8'd0;
         req_last_char <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (text_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_beat = text_q.pop_front();
            req_valid     <= 1'b1;
            req_in_char   <= next_beat.ch;
            req_last_char <= next_beat.last;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver back-pressure, redrawn each cycle
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // every accepted input beat feeds the predictor
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         normalize_beat(req_in_char, req_last_char);
         beats_taken++;
         if (req_last_char) begin
            texts_done++;
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         got_beat.out_char    = rsp_out_char;
         got_beat.char_valid  = rsp_char_valid;
         got_beat.end_of_text = rsp_end_of_text;
         bytes_seen++;
         if (clean_q.size() == 0) begin
            $error("unexpected result beat: out_char %0d char_valid %0d end_of_text %0d",
                   got_beat.out_char, got_beat.char_valid, got_beat.end_of_text);
            errors++;
         end else begin
            want_beat = clean_q.pop_front();
            if (got_beat.out_char !== want_beat.out_char) begin
               $error("out_char expected %0d actual %0d",
                      want_beat.out_char, got_beat.out_char);
               errors++;
            end
            if (got_beat.char_valid !== want_beat.char_valid) begin
               $error("char_valid expected %0d actual %0d",
                      want_beat.char_valid, got_beat.char_valid);
               errors++;
            end
            if (got_beat.end_of_text !== want_beat.end_of_text) begin
               $error("end_of_text expected %0d actual %0d",
                      want_beat.end_of_text, got_beat.end_of_text);
               errors++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic push_beat(input logic [7:0] ch, input logic last);
      char_beat_type b;
      b.ch   = ch;
      b.last = last;
      text_q.push_back(b);
      beats_pushed++;
   endtask

   // a whole text from a string, last byte flagged
   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         push_beat(s[i], i == s.len() - 1);
      end
   endtask

   // random byte weighted toward spaces, marks and letters
   function automatic logic [7:0] pick_char();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 22) begin
         return CH_SPACE;
      end else if (r < 32) begin
         return CH_PERIOD;
      end else if (r < 42) begin
         return CH_COMMA;
      end else if (r < 62) begin
         return 8'($urandom_range(CH_LOWER_A, CH_LOWER_Z));
      end else if (r < 77) begin
         return 8'($urandom_range(CH_UPPER_A, CH_UPPER_Z));
      end
      return 8'($urandom_range(255));
   endfunction

   // every pushed beat accepted and every expected byte received
   task automatic wait_drained();
      while (beats_taken != beats_pushed || clean_q.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // one random text; a cut point >= 0 stops the sender there until all is drained
   task automatic push_random_text(input int cut);
      int unsigned len;
      len = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 14);
      for (int i = 0; i < len; i++) begin
         if (i == cut) begin
            wait_drained();
         end
         push_beat(pick_char(), i == len - 1);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed texts
      // leading spaces and a leading mark, spaces inside a mark run, capital after
      push_text("  ,a . ,Z");
      // lowercase a as first byte out, bytes just outside the letter ranges
      push_text("a@[`{z");
      // only spaces: bare end marker
      push_text("  ");
      // capital kept as first byte, nul and 0xff pass through, text ends on a mark
      push_beat(8'd81, 1'b0);
      push_beat(CH_NUL, 1'b0);
      push_beat(8'hff, 1'b0);
      push_beat(CH_LOWER_A + 8'd23, 1'b0);
      push_beat(CH_SPACE, 1'b0);
      push_beat(CH_PERIOD, 1'b1);
      // text ends on a held space
      push_text("k ");
      wait_drained();

      // random texts over three idle patterns
      for (int phase = 0; phase < 3; phase++) begin
         int unsigned phase_start;
         case (phase)
            0: begin
               send_idle_pct = 38;
               recv_idle_pct = 71;
            end
            1: begin
               send_idle_pct = 71;
               recv_idle_pct = 38;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         phase_start = beats_pushed;
         while (beats_pushed - phase_start < 135) begin
            // sender stalls mid-text once in a while until the output is empty
            push_random_text(($urandom_range(15) == 0) ? 1 : -1);
         end
         wait_drained();
      end

      // let any stray result show up
      repeat (12) @(posedge clock);
      $display("tb: %0d texts, %0d bytes in, %0d result beats checked",
               texts_done, beats_taken, bytes_seen);
      $display("tb: idle patterns 38/71, 71/38 and none, with mid-text sender stalls");
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #4000000;
      $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire
